/* hw/rtl/mandelbrot_escape_time_pixel_top_defines.svh */
// Assertion macros for the Mandelbrot escape-time pixel block.
// Included by the top level; relies on clk and rst_n being in scope.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define METP_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("metp assertion failed");

// Next-cycle implication, disabled while reset is held.
`define METP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("metp assertion failed");

`endif

/* hw/rtl/metp_pkg.sv */
// Shared types, constants and helper functions of the escape-time pixel block.
// Used by every module in hw/rtl; has no dependencies.
`timescale 1ns / 1ps

package metp_pkg;

  // Field and datapath widths.
  localparam int COORD_W   = 48;
  localparam int FRAC_W    = COORD_W - 4;
  localparam int ITER_W    = 16;
  localparam int DIM_W     = 12;
  localparam int SIZE_W    = DIM_W + 1;
  localparam int OFS_W     = DIM_W + 2;
  localparam int STEP_W    = COORD_W - 1;
  localparam int HUE_W     = 9;
  localparam int HALF_W    = 25;
  localparam int MUL_W     = 2 * HALF_W;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SCALED_W  = 25;
  localparam int CUBE_W    = 3 * SCALED_W;
  localparam int MCUBE_W   = 3 * ITER_W;
  localparam int ROOT_W    = 13;
  localparam int RSQ_W     = 2 * ROOT_W;
  localparam int BIT_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;
  localparam int HUE_MOD   = 360;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   wide_t;

  localparam coord_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] ESC_MAG = COORD_W'(64'd2 << FRAC_W);
  localparam logic [COORD_W:0]   ESC_SQ  = (COORD_W+1)'(64'd4 << FRAC_W);

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_MAP, S_MAP_WAIT, S_ITER_TEST, S_ITER_WAIT, S_HSQ, S_HSQ_WAIT,
    S_HCU, S_HCU_WAIT, S_HBIT, S_HBIT_WAIT, S_FINISH
  } state_t;

  // Operand selection for the multiplier bank.
  typedef enum logic [2:0] {
    MOP_MAP, MOP_ITER, MOP_HSQ, MOP_HCU, MOP_HBIT
  } mul_op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_CENTER_RE      = 3'd2,
    REG_CENTER_IM      = 3'd3,
    REG_PIXEL_STEP     = 3'd4,
    REG_MAX_ITERATIONS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic    load_in;
    logic    mul_start;
    mul_op_t mul_op;
    logic    map_load;
    logic    iter_upd;
    logic    sq_load;
    logic    root_init;
    logic    root_upd;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic at_max;
    logic big_mag;
    logic sum_escape;
    logic root_last;
  } sts_t;

  // Clamp a one-bit-wider signed value to the coordinate range.
  function automatic coord_t clamp_c(wide_t v);
    coord_t r;
    if (v > wide_t'(CMAX)) r = CMAX;
    else if (v < wide_t'(CMIN)) r = CMIN;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  // Apply a sign to a truncated product magnitude and saturate it.
  function automatic coord_t sat_mag(logic [PROD_W-1:0] m, logic neg);
    logic [PROD_W-1:0] lim;
    logic [COORD_W-1:0] low;
    coord_t r;
    lim = PROD_W'(CMAX);
    low = m[COORD_W-1:0];
    if (neg) r = (m > lim) ? CMIN : coord_t'(~low + 1'b1);
    else r = (m > lim) ? CMAX : coord_t'(low);
    return r;
  endfunction

  // Magnitude of a coordinate; the most negative value maps to 2^(COORD_W-1).
  function automatic logic [COORD_W-1:0] mag_c(coord_t v);
    logic [COORD_W-1:0] u;
    u = v;
    return v[COORD_W-1] ? (~u + 1'b1) : u;
  endfunction

  // Reduce the root modulo 360 by restoring subtraction of scaled moduli.
  function automatic logic [HUE_W-1:0] hue_mod(logic [ROOT_W-1:0] k);
    logic [ROOT_W-1:0] r;
    r = k;
    for (int j = 4; j >= 0; j--) begin
      if (r >= ROOT_W'(HUE_MOD << j)) r = r - ROOT_W'(HUE_MOD << j);
    end
    return r[HUE_W-1:0];
  endfunction

endpackage

/* hw/rtl/metp_mul.sv */
// Unsigned 50x50 multiplier built from one 25x25 partial product per cycle.
// Depends on metp_pkg; operands must stay stable until done.
`timescale 1ns / 1ps

module metp_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [metp_pkg::MUL_W-1:0]   a,
  input  logic [metp_pkg::MUL_W-1:0]   b,
  output logic [metp_pkg::PROD_W-1:0]  prod,
  output logic                         done
);

  logic                         busy_r;
  logic [1:0]                   cnt_r;
  logic                         ppv_r;
  logic                         done_r;
  logic [metp_pkg::MUL_W-1:0]   pp_r;
  logic [metp_pkg::MUL_W-1:0]   pp_nxt;
  logic [1:0]                   pps_r;
  logic [metp_pkg::PROD_W-1:0]  acc_r;
  logic [1:0]                   sel;
  logic [metp_pkg::HALF_W-1:0]  ah;
  logic [metp_pkg::HALF_W-1:0]  bh;
  logic [metp_pkg::PROD_W-1:0]  pp_shifted;

  // Select the operand halves of the current partial product.
  always_comb begin
    sel    = start ? 2'd0 : cnt_r;
    ah     = sel[1] ? a[metp_pkg::MUL_W-1:metp_pkg::HALF_W] : a[metp_pkg::HALF_W-1:0];
    bh     = sel[0] ? b[metp_pkg::MUL_W-1:metp_pkg::HALF_W] : b[metp_pkg::HALF_W-1:0];
    pp_nxt = ah * bh;
  end

  // Align the registered partial product for accumulation.
  always_comb begin
    case (pps_r)
      2'd0:    pp_shifted = metp_pkg::PROD_W'(pp_r);
      2'd1:    pp_shifted = metp_pkg::PROD_W'(pp_r) << metp_pkg::HALF_W;
      default: pp_shifted = metp_pkg::PROD_W'(pp_r) << metp_pkg::MUL_W;
    endcase
  end

  // Sequencing control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
      ppv_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= ppv_r && !busy_r && !start;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd1;
        ppv_r  <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        ppv_r <= 1'b1;
        if (cnt_r == 2'd3) busy_r <= 1'b0;
      end else begin
        ppv_r <= 1'b0;
      end
    end
  end

  // Partial product register and accumulator.
  always_ff @(posedge clk) begin
    if (start || busy_r) begin
      pp_r  <= pp_nxt;
      pps_r <= {1'b0, sel[1]} + {1'b0, sel[0]};
    end
    if (start) acc_r <= '0;
    else if (ppv_r) acc_r <= acc_r + pp_shifted;
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

/* hw/rtl/metp_dp.sv */
// Datapath: configuration registers, pixel mapping, orbit iteration, hue root search.
// Depends on metp_pkg and metp_mul; driven by commands from metp_ctrl.
`timescale 1ns / 1ps

module metp_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [metp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [metp_pkg::CFG_W-1:0]       cfg_data,
  input  logic [metp_pkg::DIM_W-1:0]       in_pixel_x,
  input  logic [metp_pkg::DIM_W-1:0]       in_pixel_y,
  input  metp_pkg::cmd_t                   cmd,
  output metp_pkg::sts_t                   sts,
  output logic [metp_pkg::ITER_W-1:0]      out_iteration_count,
  output logic                             out_inside_set,
  output logic [metp_pkg::HUE_W-1:0]       out_hue_degrees
);

  // Configuration registers.
  logic [metp_pkg::SIZE_W-1:0]   width_r;
  logic [metp_pkg::SIZE_W-1:0]   height_r;
  metp_pkg::coord_t              center_re_r;
  metp_pkg::coord_t              center_im_r;
  logic [metp_pkg::STEP_W-1:0]   step_r;
  logic [metp_pkg::ITER_W-1:0]   max_r;

  // Working registers.
  logic [metp_pkg::DIM_W-1:0]    px_r;
  logic [metp_pkg::DIM_W-1:0]    py_r;
  metp_pkg::coord_t              c_re_r;
  metp_pkg::coord_t              c_im_r;
  metp_pkg::coord_t              re_r;
  metp_pkg::coord_t              im_r;
  logic [metp_pkg::ITER_W-1:0]   n_r;
  logic [metp_pkg::MUL_W-1:0]    sq_r;
  logic [metp_pkg::MUL_W-1:0]    msq_r;
  logic [metp_pkg::CUBE_W-1:0]   cube_r;
  logic [metp_pkg::MCUBE_W-1:0]  mcube_r;
  logic [metp_pkg::ROOT_W-1:0]   root_r;
  logic [metp_pkg::RSQ_W-1:0]    rsq_r;
  logic [metp_pkg::BIT_W-1:0]    bit_r;
  logic [metp_pkg::ITER_W-1:0]   out_count_r;
  logic                          out_inside_r;
  logic [metp_pkg::HUE_W-1:0]    out_hue_r;

  // Combinational values.
  logic signed [metp_pkg::OFS_W-1:0] dx;
  logic signed [metp_pkg::OFS_W-1:0] dy;
  logic [metp_pkg::OFS_W-1:0]    dx_mag;
  logic [metp_pkg::OFS_W-1:0]    dy_mag;
  logic [metp_pkg::COORD_W-1:0]  re_mag;
  logic [metp_pkg::COORD_W-1:0]  im_mag;
  logic [metp_pkg::SCALED_W-1:0] scaled;
  logic [metp_pkg::RSQ_W-1:0]    tsq;
  logic [metp_pkg::MUL_W-1:0]    a0, b0, a1, b1, a2, b2;
  logic [metp_pkg::PROD_W-1:0]   p0, p1, p2;
  logic                          done0, done1, done2;
  metp_pkg::coord_t              tx, ty, re2, im2, ri, ri2, c_re_nxt, c_im_nxt;
  logic                          at_max;

  // Offsets from the image center, doubled so odd sizes keep the half pixel.
  always_comb begin
    dx     = {1'b0, px_r, 1'b0} - {1'b0, width_r};
    dy     = {1'b0, py_r, 1'b0} - {1'b0, height_r};
    dx_mag = dx[metp_pkg::OFS_W-1] ? (~dx + 1'b1) : dx;
    dy_mag = dy[metp_pkg::OFS_W-1] ? (~dy + 1'b1) : dy;
    re_mag = metp_pkg::mag_c(re_r);
    im_mag = metp_pkg::mag_c(im_r);
    scaled = metp_pkg::SCALED_W'(n_r) * metp_pkg::SCALED_W'(metp_pkg::HUE_MOD);
    tsq    = rsq_r + (metp_pkg::RSQ_W'(root_r) << (bit_r + 1'b1))
             + (metp_pkg::RSQ_W'(1) << {bit_r, 1'b0});
    at_max = n_r >= max_r;
  end

  // Operand selection for the three multipliers.
  always_comb begin
    a0 = '0; b0 = '0; a1 = '0; b1 = '0; a2 = '0; b2 = '0;
    case (cmd.mul_op)
      metp_pkg::MOP_MAP: begin
        a0 = metp_pkg::MUL_W'(dx_mag); b0 = metp_pkg::MUL_W'(step_r);
        a1 = metp_pkg::MUL_W'(dy_mag); b1 = metp_pkg::MUL_W'(step_r);
      end
      metp_pkg::MOP_ITER: begin
        a0 = metp_pkg::MUL_W'(re_mag); b0 = metp_pkg::MUL_W'(re_mag);
        a1 = metp_pkg::MUL_W'(im_mag); b1 = metp_pkg::MUL_W'(im_mag);
        a2 = metp_pkg::MUL_W'(re_mag); b2 = metp_pkg::MUL_W'(im_mag);
      end
      metp_pkg::MOP_HSQ: begin
        a0 = metp_pkg::MUL_W'(scaled); b0 = metp_pkg::MUL_W'(scaled);
        a1 = metp_pkg::MUL_W'(max_r);  b1 = metp_pkg::MUL_W'(max_r);
      end
      metp_pkg::MOP_HCU: begin
        a0 = sq_r;  b0 = metp_pkg::MUL_W'(scaled);
        a1 = msq_r; b1 = metp_pkg::MUL_W'(max_r);
      end
      metp_pkg::MOP_HBIT: begin
        a0 = metp_pkg::MUL_W'(tsq); b0 = metp_pkg::MUL_W'(mcube_r);
      end
      default: begin
        a0 = '0;
      end
    endcase
  end

  metp_mul u_mul0 (.clk(clk), .rst_n(rst_n), .start(cmd.mul_start), .a(a0), .b(b0),
                   .prod(p0), .done(done0));
  metp_mul u_mul1 (.clk(clk), .rst_n(rst_n), .start(cmd.mul_start), .a(a1), .b(b1),
                   .prod(p1), .done(done1));
  metp_mul u_mul2 (.clk(clk), .rst_n(rst_n), .start(cmd.mul_start), .a(a2), .b(b2),
                   .prod(p2), .done(done2));

  // Truncated, saturated products and the next orbit values.
  always_comb begin
    tx  = metp_pkg::sat_mag(p0 >> 1, dx[metp_pkg::OFS_W-1]);
    ty  = metp_pkg::sat_mag(p1 >> 1, dy[metp_pkg::OFS_W-1]);
    c_re_nxt = metp_pkg::clamp_c(metp_pkg::wide_t'(tx) + metp_pkg::wide_t'(center_re_r));
    c_im_nxt = metp_pkg::clamp_c(metp_pkg::wide_t'(ty) - metp_pkg::wide_t'(center_im_r));
    re2 = metp_pkg::sat_mag(p0 >> metp_pkg::FRAC_W, 1'b0);
    im2 = metp_pkg::sat_mag(p1 >> metp_pkg::FRAC_W, 1'b0);
    ri  = metp_pkg::sat_mag(p2 >> metp_pkg::FRAC_W,
                            re_r[metp_pkg::COORD_W-1] ^ im_r[metp_pkg::COORD_W-1]);
    ri2 = metp_pkg::clamp_c(metp_pkg::wide_t'(ri) + metp_pkg::wide_t'(ri));
  end

  // Status back to the controller.
  always_comb begin
    sts.mul_done   = done0 && done1 && done2;
    sts.at_max     = at_max;
    sts.big_mag    = (re_mag > metp_pkg::ESC_MAG) || (im_mag > metp_pkg::ESC_MAG);
    sts.sum_escape = ({1'b0, re2} + {1'b0, im2}) > metp_pkg::ESC_SQ;
    sts.root_last  = bit_r == '0;
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= metp_pkg::SIZE_W'(640);
      height_r    <= metp_pkg::SIZE_W'(480);
      center_re_r <= '0;
      center_im_r <= '0;
      step_r      <= metp_pkg::STEP_W'(1) << (metp_pkg::FRAC_W - 2);
      max_r       <= metp_pkg::ITER_W'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        metp_pkg::REG_IMAGE_WIDTH:    width_r     <= cfg_data[metp_pkg::SIZE_W-1:0];
        metp_pkg::REG_IMAGE_HEIGHT:   height_r    <= cfg_data[metp_pkg::SIZE_W-1:0];
        metp_pkg::REG_CENTER_RE:      center_re_r <= cfg_data[metp_pkg::COORD_W-1:0];
        metp_pkg::REG_CENTER_IM:      center_im_r <= cfg_data[metp_pkg::COORD_W-1:0];
        metp_pkg::REG_PIXEL_STEP:     step_r      <= cfg_data[metp_pkg::STEP_W-1:0];
        metp_pkg::REG_MAX_ITERATIONS: max_r       <= cfg_data[metp_pkg::ITER_W-1:0];
        default: begin
          max_r <= max_r;
        end
      endcase
    end
  end

  // Pixel, orbit and root search registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
    if (cmd.map_load) begin
      c_re_r <= c_re_nxt;
      c_im_r <= c_im_nxt;
      re_r   <= c_re_nxt;
      im_r   <= c_im_nxt;
      n_r    <= '0;
    end else if (cmd.iter_upd) begin
      re_r <= metp_pkg::clamp_c(metp_pkg::wide_t'(re2) - metp_pkg::wide_t'(im2)
                                + metp_pkg::wide_t'(c_re_r));
      im_r <= metp_pkg::clamp_c(metp_pkg::wide_t'(ri2) + metp_pkg::wide_t'(c_im_r));
      n_r  <= n_r + 1'b1;
    end
    if (cmd.sq_load) begin
      sq_r  <= p0[metp_pkg::MUL_W-1:0];
      msq_r <= p1[metp_pkg::MUL_W-1:0];
    end
    if (cmd.root_init) begin
      cube_r  <= p0[metp_pkg::CUBE_W-1:0];
      mcube_r <= p1[metp_pkg::MCUBE_W-1:0];
      root_r  <= '0;
      rsq_r   <= '0;
      bit_r   <= metp_pkg::BIT_W'(metp_pkg::ROOT_W - 1);
    end else if (cmd.root_upd) begin
      // Keep the trial bit when trial^2 * max^3 does not exceed (360*n)^3.
      if (p0 <= metp_pkg::PROD_W'(cube_r)) begin
        root_r <= root_r | (metp_pkg::ROOT_W'(1) << bit_r);
        rsq_r  <= tsq;
      end
      bit_r <= bit_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_count_r  <= n_r;
      out_inside_r <= at_max;
      out_hue_r    <= at_max ? '0 : metp_pkg::hue_mod(root_r);
    end
  end

  assign out_iteration_count = out_count_r;
  assign out_inside_set      = out_inside_r;
  assign out_hue_degrees     = out_hue_r;

endmodule

/* hw/rtl/metp_ctrl.sv */
// Controller state machine: sequences mapping, iteration and hue search.
// Depends on metp_pkg; talks to metp_dp through cmd_t and sts_t.
`timescale 1ns / 1ps

module metp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  metp_pkg::sts_t  sts,
  output metp_pkg::cmd_t  cmd
);

  metp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      metp_pkg::S_IDLE:      if (in_valid) state_nxt = metp_pkg::S_MAP;
      metp_pkg::S_MAP:       state_nxt = metp_pkg::S_MAP_WAIT;
      metp_pkg::S_MAP_WAIT:  if (sts.mul_done) state_nxt = metp_pkg::S_ITER_TEST;
      metp_pkg::S_ITER_TEST: begin
        if (sts.at_max) state_nxt = metp_pkg::S_FINISH;
        else if (sts.big_mag) state_nxt = metp_pkg::S_HSQ;
        else state_nxt = metp_pkg::S_ITER_WAIT;
      end
      metp_pkg::S_ITER_WAIT: begin
        if (sts.mul_done) begin
          state_nxt = sts.sum_escape ? metp_pkg::S_HSQ : metp_pkg::S_ITER_TEST;
        end
      end
      metp_pkg::S_HSQ:       state_nxt = metp_pkg::S_HSQ_WAIT;
      metp_pkg::S_HSQ_WAIT:  if (sts.mul_done) state_nxt = metp_pkg::S_HCU;
      metp_pkg::S_HCU:       state_nxt = metp_pkg::S_HCU_WAIT;
      metp_pkg::S_HCU_WAIT:  if (sts.mul_done) state_nxt = metp_pkg::S_HBIT;
      metp_pkg::S_HBIT:      state_nxt = metp_pkg::S_HBIT_WAIT;
      metp_pkg::S_HBIT_WAIT: begin
        if (sts.mul_done) begin
          state_nxt = sts.root_last ? metp_pkg::S_FINISH : metp_pkg::S_HBIT;
        end
      end
      metp_pkg::S_FINISH:    if (out_free) state_nxt = metp_pkg::S_IDLE;
      default:               state_nxt = metp_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.mul_op    = metp_pkg::MOP_MAP;
    case (state_r)
      metp_pkg::S_IDLE:      cmd.load_in = in_valid;
      metp_pkg::S_MAP:       cmd.mul_start = 1'b1;
      metp_pkg::S_MAP_WAIT:  cmd.map_load = sts.mul_done;
      metp_pkg::S_ITER_TEST: begin
        cmd.mul_op    = metp_pkg::MOP_ITER;
        cmd.mul_start = !sts.at_max && !sts.big_mag;
      end
      metp_pkg::S_ITER_WAIT: begin
        cmd.mul_op   = metp_pkg::MOP_ITER;
        cmd.iter_upd = sts.mul_done && !sts.sum_escape;
      end
      metp_pkg::S_HSQ: begin
        cmd.mul_op    = metp_pkg::MOP_HSQ;
        cmd.mul_start = 1'b1;
      end
      metp_pkg::S_HSQ_WAIT: begin
        cmd.mul_op  = metp_pkg::MOP_HSQ;
        cmd.sq_load = sts.mul_done;
      end
      metp_pkg::S_HCU: begin
        cmd.mul_op    = metp_pkg::MOP_HCU;
        cmd.mul_start = 1'b1;
      end
      metp_pkg::S_HCU_WAIT: begin
        cmd.mul_op    = metp_pkg::MOP_HCU;
        cmd.root_init = sts.mul_done;
      end
      metp_pkg::S_HBIT: begin
        cmd.mul_op    = metp_pkg::MOP_HBIT;
        cmd.mul_start = 1'b1;
      end
      metp_pkg::S_HBIT_WAIT: begin
        cmd.mul_op   = metp_pkg::MOP_HBIT;
        cmd.root_upd = sts.mul_done;
      end
      metp_pkg::S_FINISH:    cmd.out_load = out_free;
      default:               cmd.load_in = 1'b0;
    endcase
  end

  // Output valid: set when a result is loaded, cleared once it is taken.
  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= metp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == metp_pkg::S_IDLE;
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/mandelbrot_escape_time_pixel_top.sv */
// Top level of the Mandelbrot escape-time pixel evaluator.
// Depends on metp_pkg, metp_ctrl, metp_dp (with metp_mul) and the defines header.
//
// Usage: software writes the view registers over the cfg channel (index, data;
// cfg_ready is always high) while the block is idle. Each in transaction
// carries one pixel (x, y); each out transaction returns its iteration count,
// inside flag and hue. One result per pixel, in order.
// Each pixel is mapped to c and then iterated once per orbit step; an escaped
// pixel then runs a hue root search, which a pixel that reaches the limit skips.
// The iteration count n of a pixel is at most max_iterations.
// Each 50x50 product of the multiplier bank is four passes through one 25x25
// multiplier plus a final accumulate.
// One pixel is worked on at a time; in_ready is high while the controller is
// idle. The result sits in an output register, so the next pixel is accepted
// while the receiver stalls; a finished pixel waits only if that register is
// still full. Synchronous reset restores the register defaults and empties
// the pipeline.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_pixel_top_defines.svh"

module mandelbrot_escape_time_pixel_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [metp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [metp_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [metp_pkg::DIM_W-1:0]      in_pixel_x,
  input  logic [metp_pkg::DIM_W-1:0]      in_pixel_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [metp_pkg::ITER_W-1:0]     out_iteration_count,
  output logic                            out_inside_set,
  output logic [metp_pkg::HUE_W-1:0]      out_hue_degrees
);

  metp_pkg::cmd_t cmd;
  metp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // Controller.
  metp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  metp_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_iteration_count (out_iteration_count),
    .out_inside_set      (out_inside_set),
    .out_hue_degrees     (out_hue_degrees)
  );

  // A pixel accepted means the controller is busy on the next cycle.
  `METP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // Pixels inside the set carry no hue.
  `METP_ASSERT_IMPL(a_inside_no_hue, out_valid && out_inside_set, out_hue_degrees == '0)
  // The hue is always reduced below a full turn.
  `METP_ASSERT_IMPL(a_hue_range, out_valid, out_hue_degrees < metp_pkg::HUE_W'(metp_pkg::HUE_MOD))

endmodule

/* test/testbench.sv */
// Self-checking testbench for the Mandelbrot escape-time pixel block.
// Depends on metp_pkg and mandelbrot_escape_time_pixel_top; needs nothing else.
// A scoreboard class predicts each pixel result and checks results in order.
`timescale 1ns / 1ps

class escape_board;
  typedef struct {
    logic [15:0] count;
    logic        in_set;
    logic [8:0]  hue;
  } pixel_result_t;

  localparam longint CMAX_V = (longint'(1) << 47) - 1;
  localparam longint CMIN_V = -(longint'(1) << 47);
  localparam longint ONE_V  = longint'(1) << 44;

  pixel_result_t expected_q[$];
  longint width, height, ctr_re, ctr_im, step, max_iter;
  int     mismatches;
  int     results_seen;
  int     inside_seen;

  function new();
    reset_regs();
    mismatches   = 0;
    results_seen = 0;
    inside_seen  = 0;
  endfunction

  function void reset_regs();
    width    = 640;
    height   = 480;
    ctr_re   = 0;
    ctr_im   = 0;
    step     = ONE_V >> 2;
    max_iter = 256;
  endfunction

  // Register write with the field masks and sign extension of the hardware.
  function void set_reg(logic [2:0] idx, logic [47:0] val);
    case (idx)
      metp_pkg::REG_IMAGE_WIDTH:    width    = longint'(val[12:0]);
      metp_pkg::REG_IMAGE_HEIGHT:   height   = longint'(val[12:0]);
      metp_pkg::REG_CENTER_RE:      ctr_re   = longint'(signed'(val));
      metp_pkg::REG_CENTER_IM:      ctr_im   = longint'(signed'(val));
      metp_pkg::REG_PIXEL_STEP:     step     = longint'(val[46:0]);
      metp_pkg::REG_MAX_ITERATIONS: max_iter = longint'(val[15:0]);
      default: ;
    endcase
  endfunction

  function longint clamp_coord(longint v);
    if (v > CMAX_V) return CMAX_V;
    if (v < CMIN_V) return CMIN_V;
    return v;
  endfunction

  function longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Product shifted right, truncated toward zero on its magnitude, saturated.
  function longint fixed_mul(longint a, longint b, int sh);
    logic [127:0] ma, mb, p;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = 128'(magnitude(a));
    mb = 128'(magnitude(b));
    p = (ma * mb) >> sh;
    if (neg) begin
      if (p >= 128'(CMAX_V) + 1) return CMIN_V;
      return -longint'(p[63:0]);
    end
    if (p > 128'(CMAX_V)) return CMAX_V;
    return longint'(p[63:0]);
  endfunction

  // Largest k with k^2 * max^3 <= (360 n)^3, reduced modulo 360.
  function logic [8:0] hue_for(longint n, longint mx);
    logic [127:0] a, a3, m3, t;
    longint lo, hi, mid;
    a = 128'(360 * n);
    a3 = a * a * a;
    m3 = 128'(mx) * 128'(mx) * 128'(mx);
    lo = 0;
    hi = 8191;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 128'(mid * mid) * m3;
      if (t <= a3) lo = mid;
      else hi = mid - 1;
    end
    return 9'(lo % 360);
  endfunction

  function pixel_result_t evaluate_pixel(logic [11:0] px, logic [11:0] py);
    pixel_result_t r;
    longint cre, cim, re, im, re2, im2, ri, n;
    longint two, four;
    two  = 2 * ONE_V;
    four = 4 * ONE_V;
    cre = clamp_coord(fixed_mul(2 * longint'(px) - width, step, 1) + ctr_re);
    cim = clamp_coord(fixed_mul(2 * longint'(py) - height, step, 1) - ctr_im);
    re = cre;
    im = cim;
    n = 0;
    while (n < max_iter) begin
      if (magnitude(re) > two || magnitude(im) > two) break;
      re2 = fixed_mul(re, re, 44);
      im2 = fixed_mul(im, im, 44);
      if (re2 + im2 > four) break;
      ri = fixed_mul(re, im, 44);
      re = clamp_coord(re2 - im2 + cre);
      im = clamp_coord(clamp_coord(ri + ri) + cim);
      n++;
    end
    r.count = 16'(n);
    if (n < max_iter) begin
      r.in_set = 1'b0;
      r.hue = hue_for(n, max_iter);
    end else begin
      r.in_set = 1'b1;
      r.hue = 9'd0;
    end
    return r;
  endfunction

  function void note_pixel(logic [11:0] px, logic [11:0] py);
    expected_q.push_back(evaluate_pixel(px, py));
  endfunction

  function void check_result(logic [15:0] count, logic in_set, logic [8:0] hue);
    pixel_result_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result with no pixel pending: count=%0d inside=%0d hue=%0d",
                 count, in_set, hue);
      return;
    end
    e = expected_q.pop_front();
    if (in_set) inside_seen++;
    if (count !== e.count || in_set !== e.in_set || hue !== e.hue) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d: expected count=%0d inside=%0d hue=%0d, got %0d %0d %0d",
                 results_seen, e.count, e.in_set, e.hue, count, in_set, hue);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 20;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam longint ONE_Q = longint'(1) << 44;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] in_pixel_x;
  logic [11:0] in_pixel_y;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_iteration_count;
  logic        out_inside_set;
  logic [8:0]  out_hue_degrees;

  escape_board board;
  int sender_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int stall_cycles;
  int pixels_sent;

  mandelbrot_escape_time_pixel_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_iteration_count (out_iteration_count),
    .out_inside_set      (out_inside_set),
    .out_hue_degrees     (out_hue_degrees)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: note accepted pixels and check accepted results at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_pixel(in_pixel_x, in_pixel_y);
      if (out_valid && out_ready)
        board.check_result(out_iteration_count, out_inside_set, out_hue_degrees);
    end
  end

  // Watchdog: end the run if no transaction completes for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog expired with %0d results pending", board.pending());
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    in_pixel_x = px;
    in_pixel_y = py;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait until every result has arrived, then let the block settle.
  task automatic drain();
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_view(input longint w, input longint h, input longint cre,
                          input longint cim, input longint stp, input longint mx);
    drain();
    write_reg(metp_pkg::REG_IMAGE_WIDTH, 48'(w));
    write_reg(metp_pkg::REG_IMAGE_HEIGHT, 48'(h));
    write_reg(metp_pkg::REG_CENTER_RE, 48'(cre));
    write_reg(metp_pkg::REG_CENTER_IM, 48'(cim));
    write_reg(metp_pkg::REG_PIXEL_STEP, 48'(stp));
    write_reg(metp_pkg::REG_MAX_ITERATIONS, 48'(mx));
  endtask

  // Random view: mostly a sensible window near the set, sometimes raw bit patterns.
  task automatic random_view(input bit wild);
    longint w, h, cre, cim, stp, mx;
    if (wild) begin
      w   = $urandom_range(8191);
      h   = $urandom_range(8191);
      cre = {$urandom, $urandom};
      cim = {$urandom, $urandom};
      stp = longint'({$urandom, $urandom}) & ((longint'(1) << 47) - 1);
      if ($urandom_range(1)) stp = stp >> $urandom_range(47);
      mx  = $urandom_range(1, 40);
    end else begin
      w   = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 256);
      h   = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 256);
      cre = (longint'($urandom_range(3000)) - 2000) * (ONE_Q / 1000);
      cim = (longint'($urandom_range(2400)) - 1200) * (ONE_Q / 1000);
      stp = (longint'($urandom_range(1, 4000)) * ONE_Q) / (1000 * (w + 1));
      stp = stp >> $urandom_range(6);
      mx  = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 64);
    end
    set_view(w, h, cre, cim, stp, mx);
  endtask

  task automatic random_pixels(input int count);
    logic [11:0] px, py;
    int w, h;
    for (int i = 0; i < count; i++) begin
      w = int'(board.width);
      h = int'(board.height);
      if ($urandom_range(99) < 80 && w > 0 && h > 0) begin
        px = 12'($urandom_range((w > 4096) ? 4095 : w - 1));
        py = 12'($urandom_range((h > 4096) ? 4095 : h - 1));
      end else begin
        px = 12'($urandom);
        py = 12'($urandom);
      end
      send_pixel(px, py);
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = metp_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    out_ready = 1'b0;
    hold_left = 0;
    stall_cycles = 0;
    pixels_sent = 0;
    sender_idle_pct = 30;
    recv_idle_pct = 84;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: corners of the pixel coordinate range and centre of the reset view.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd300, 12'd250);

    // Zero step on the boundary point -2, which never escapes.
    set_view(640, 480, -2 * ONE_Q, 0, 0, 16);
    send_pixel(12'd5, 12'd7);
    // Odd dimensions give a half-pixel offset.
    set_view(1, 4095, -ONE_Q / 2, ONE_Q / 4, ONE_Q / 3, 32);
    send_pixel(12'd0, 12'd2047);
    send_pixel(12'd0, 12'd2048);
    // Largest step and the widest width field saturate the coordinates.
    set_view(8191, 0, 0, 0, (longint'(1) << 47) - 1, 8);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    // Extreme centres.
    set_view(4096, 4096, -(longint'(1) << 47), (longint'(1) << 47) - 1, 1, 1);
    send_pixel(12'd2048, 12'd2048);
    // Largest iteration limit far outside the set, then a zero limit.
    set_view(640, 480, 7 * ONE_Q, 0, 1, 65535);
    send_pixel(12'd1, 12'd2);
    set_view(640, 480, 0, 0, ONE_Q >> 2, 0);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd0, 12'd0);
    // Limit of one inside the set; spare register indexes must be ignored.
    set_view(640, 480, -ONE_Q / 4, 0, ONE_Q >> 8, 1);
    write_reg(REG_SPARE_LO, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_SPARE_HI, 48'h1234_5678_9ABC);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd100, 12'd100);

    // Random phases through the three idling modes.
    for (int ph = 0; ph < 9; ph++) begin
      random_view(ph == 8 || ph == 4);
      if (ph < 3) begin
        sender_idle_pct = 30;
        recv_idle_pct = 84;
      end else if (ph < 6) begin
        sender_idle_pct = 84;
        recv_idle_pct = 30;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Long receiver hold-off while pixels keep coming, to fill the block.
      if (ph == 6) hold_left = 3000;
      random_pixels(90);
    end
    drain();

    $display("Covered %0d pixels over directed and random views, %0d results, %0d inside.",
             pixels_sent, board.results_seen, board.inside_seen);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches, board.pending());
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
